// ----- hdl/mandelbrot_escape_blend_defines.svh -----
// ---------------------------------------------------------------------------
// Mandelbrot escape blend: assertion macros
// Shared property shorthands; each expects clock and reset in scope.
// ---------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_BLEND_DEFINES_SVH
`define MANDELBROT_ESCAPE_BLEND_DEFINES_SVH

// Same-cycle implication.
`define MEB_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define MEB_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/meb_pkg.sv -----
// ---------------------------------------------------------------------------
// Mandelbrot escape blend: shared package
// Constants, register and mode codes, controller/datapath interface types.
// ---------------------------------------------------------------------------
`default_nettype none

package meb_pkg;

   localparam int MAX_WIDTH       = 4096;
   localparam int MAX_HEIGHT      = 4096;
   localparam int COORD_FRAC_BITS = 28;

   // Escape threshold 4.0 (radius 2.0 squared) in the product scale.
   localparam bit          CAN_ESCAPE = (2 * COORD_FRAC_BITS + 2) < 64;
   localparam logic [63:0] ESC_THRESH = CAN_ESCAPE ? (64'd4 << (2 * COORD_FRAC_BITS)) : '0;

   localparam logic [2:0] REG_MIN_X    = 3'd0;
   localparam logic [2:0] REG_MIN_Y    = 3'd1;
   localparam logic [2:0] REG_STEP_X   = 3'd2;
   localparam logic [2:0] REG_STEP_Y   = 3'd3;
   localparam logic [2:0] REG_MAX_ITER = 3'd4;
   localparam logic [2:0] REG_BLEND    = 3'd5;

   localparam logic [1:0] MODE_OVERLAY  = 2'd0;
   localparam logic [1:0] MODE_ADD      = 2'd1;
   localparam logic [1:0] MODE_SUBTRACT = 2'd2;

   typedef struct packed {
      logic load;
      logic pt_mul;
      logic pt_add;
      logic it_mul;
      logic it_step;
      logic esc_take;
      logic pow_init;
      logic pow_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic iter_end;
      logic escaped;
      logic overlay;
      logic pow_done;
   } sts_type;

   // Clamp a signed sum to the 32-bit range.
   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      if (v[65:31] == '0 || v[65:31] == '1) begin
         return v[31:0];
      end else if (v[65]) begin
         return 32'sh8000_0000;
      end else begin
         return 32'sh7FFF_FFFF;
      end
   endfunction

   // floor(p / 255) for p <= 255*255, by reciprocal with rounding offset.
   function automatic logic [7:0] div255(input logic [15:0] p);
      logic [16:0] t;
      t = 17'(p) + 17'(p >> 8) + 17'd1;
      return t[15:8];
   endfunction

endpackage

`default_nettype wire

// ----- hdl/meb_ctrl.sv -----
// ---------------------------------------------------------------------------
// Mandelbrot escape blend: controller
// Sequences point setup, the escape loop, the overlay power loop and output.
// ---------------------------------------------------------------------------
`default_nettype none
`include "mandelbrot_escape_blend_defines.svh"

module meb_ctrl import meb_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   output logic         rsp_valid,
   output cmd_type      cmd,
   input  wire sts_type sts
);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_PT_MUL   = 3'd1;
   localparam logic [2:0] ST_PT_ADD   = 3'd2;
   localparam logic [2:0] ST_IT_MUL   = 3'd3;
   localparam logic [2:0] ST_IT_UPD   = 3'd4;
   localparam logic [2:0] ST_POW_INIT = 3'd5;
   localparam logic [2:0] ST_POW      = 3'd6;
   localparam logic [2:0] ST_FINISH   = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_PT_MUL;
            end
         end
         ST_PT_MUL: begin
            cmd.pt_mul = 1'b1;
            state_in   = ST_PT_ADD;
         end
         ST_PT_ADD: begin
            cmd.pt_add = 1'b1;
            state_in   = ST_IT_MUL;
         end
         ST_IT_MUL: begin
            if (sts.iter_end) begin
               state_in = ST_POW_INIT;
            end else begin
               cmd.it_mul = 1'b1;
               state_in   = ST_IT_UPD;
            end
         end
         ST_IT_UPD: begin
            if (sts.escaped) begin
               cmd.esc_take = 1'b1;
               state_in     = ST_POW_INIT;
            end else begin
               cmd.it_step = 1'b1;
               state_in    = ST_IT_MUL;
            end
         end
         ST_POW_INIT: begin
            cmd.pow_init = 1'b1;
            state_in     = sts.overlay ? ST_POW : ST_FINISH;
         end
         ST_POW: begin
            if (sts.pow_done) begin
               state_in = ST_FINISH;
            end else begin
               cmd.pow_step = 1'b1;
            end
         end
         ST_FINISH: begin
            cmd.finish   = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `MEB_ASSERT_IMP(a_strobe_in_idle, rsp_valid_ff, state_ff == ST_IDLE, "strobe outside idle")
   `MEB_ASSERT_NXT(a_finish_strobes, state_ff == ST_FINISH, rsp_valid_ff, "finish without strobe")
   `MEB_ASSERT_NXT(a_accept_setup, start && state_ff == ST_IDLE, state_ff == ST_PT_MUL, "accept lost")

endmodule

`default_nettype wire

// ----- hdl/meb_dp.sv -----
// ---------------------------------------------------------------------------
// Mandelbrot escape blend: datapath
// Config registers, shared multipliers, escape update and channel blend.
// ---------------------------------------------------------------------------
`default_nettype none
`include "mandelbrot_escape_blend_defines.svh"

module meb_dp import meb_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   output sts_type          sts,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wdata,
   input  wire logic [11:0] req_column,
   input  wire logic [11:0] req_row,
   input  wire logic [7:0]  req_red_in,
   input  wire logic [7:0]  req_green_in,
   input  wire logic [7:0]  req_blue_in,
   output logic [7:0]       rsp_red_out,
   output logic [7:0]       rsp_green_out,
   output logic [7:0]       rsp_blue_out,
   output logic [7:0]       rsp_escape_count
);

   logic signed [31:0] min_x_ff, min_y_ff;
   logic [30:0]        step_x_ff, step_y_ff;
   logic [7:0]         max_it_ff;
   logic [1:0]         mode_ff;

   logic [11:0]        col_ff, row_ff, col_in, row_in;
   logic [7:0]         red_ff, green_ff, blue_ff;
   logic signed [31:0] cx_ff, cy_ff, x_ff, y_ff;
   logic signed [63:0] prod0_ff, prod1_ff, prod2_ff;
   logic [7:0]         iter_ff, count_ff, pow_k_ff;
   logic [7:0]         v_r_ff, v_g_ff, v_b_ff;
   logic [7:0]         out_r_ff, out_g_ff, out_b_ff, out_cnt_ff;

   logic signed [31:0] mul_a0, mul_b0, mul_a1, mul_b1;
   logic signed [63:0] mul_p0, mul_p1, mul_p2;
   logic signed [63:0] xx_m_yy, x_shift, y_shift;
   logic signed [31:0] cx_in, cy_in, nx_in, ny_in;
   logic [63:0]        mag_sum;
   logic [7:0]         pow_n;
   logic [15:0]        pr_r, pr_g, pr_b;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_x_ff  <= -32'sd402653184;
         min_y_ff  <= -32'sd335544320;
         step_x_ff <= 31'd196608;
         step_y_ff <= 31'd163840;
         max_it_ff <= 8'd50;
         mode_ff   <= MODE_OVERLAY;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_MIN_X:    min_x_ff  <= csr_wdata;
            REG_MIN_Y:    min_y_ff  <= csr_wdata;
            REG_STEP_X:   step_x_ff <= csr_wdata[30:0];
            REG_STEP_Y:   step_y_ff <= csr_wdata[30:0];
            REG_MAX_ITER: max_it_ff <= csr_wdata[7:0];
            REG_BLEND:    mode_ff   <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   // Clamp coordinates to the image
   always_comb begin
      col_in = req_column;
      row_in = req_row;
      if ({5'd0, req_column} > 17'(MAX_WIDTH - 1)) begin
         col_in = 12'(MAX_WIDTH - 1);
      end
      if ({5'd0, req_row} > 17'(MAX_HEIGHT - 1)) begin
         row_in = 12'(MAX_HEIGHT - 1);
      end
   end

   // Shared multipliers: point offsets during setup, squares in the loop
   always_comb begin
      if (cmd.pt_mul) begin
         mul_a0 = signed'({20'd0, col_ff});
         mul_b0 = signed'({1'b0, step_x_ff});
         mul_a1 = signed'({20'd0, row_ff});
         mul_b1 = signed'({1'b0, step_y_ff});
      end else begin
         mul_a0 = x_ff;
         mul_b0 = x_ff;
         mul_a1 = y_ff;
         mul_b1 = y_ff;
      end
   end

   assign mul_p0 = mul_a0 * mul_b0;
   assign mul_p1 = mul_a1 * mul_b1;
   assign mul_p2 = x_ff * y_ff;

   assign cx_in = sat32(66'(min_x_ff) + 66'(prod0_ff));
   assign cy_in = sat32(66'(min_y_ff) + 66'(prod1_ff));

   assign xx_m_yy = prod0_ff - prod1_ff;
   assign x_shift = xx_m_yy >>> COORD_FRAC_BITS;
   assign y_shift = prod2_ff >>> (COORD_FRAC_BITS - 1);
   assign nx_in   = sat32(66'(x_shift) + 66'(cx_ff));
   assign ny_in   = sat32(66'(y_shift) + 66'(cy_ff));

   assign mag_sum = prod0_ff + prod1_ff;

   assign pow_n = (count_ff == 8'd0) ? 8'd1 : count_ff;
   assign pr_r  = v_r_ff * red_ff;
   assign pr_g  = v_g_ff * green_ff;
   assign pr_b  = v_b_ff * blue_ff;

   assign sts.iter_end = (iter_ff >= max_it_ff);
   assign sts.escaped  = CAN_ESCAPE && (mag_sum > ESC_THRESH);
   assign sts.overlay  = (mode_ff == MODE_OVERLAY);
   assign sts.pow_done = (pow_k_ff >= pow_n);

   function automatic logic [7:0] chan_blend(input logic [1:0] mode, input logic [7:0] v,
                                             input logic [7:0] ch, input logic [7:0] cnt);
      logic [8:0] s;
      s = {1'b0, ch} + {1'b0, cnt};
      case (mode)
         MODE_OVERLAY:  return v;
         MODE_ADD:      return s[8] ? 8'd255 : s[7:0];
         MODE_SUBTRACT: return (ch > cnt) ? (ch - cnt) : 8'd0;
         default:       return 8'd0;
      endcase
   endfunction

   // Datapath registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         red_ff   <= req_red_in;
         green_ff <= req_green_in;
         blue_ff  <= req_blue_in;
      end
      if (cmd.pt_mul || cmd.it_mul) begin
         prod0_ff <= mul_p0;
         prod1_ff <= mul_p1;
         prod2_ff <= mul_p2;
      end
      if (cmd.pt_add) begin
         cx_ff    <= cx_in;
         cy_ff    <= cy_in;
         x_ff     <= cx_in;
         y_ff     <= cy_in;
         iter_ff  <= 8'd0;
         count_ff <= 8'd0;
      end
      if (cmd.it_step) begin
         x_ff    <= nx_in;
         y_ff    <= ny_in;
         iter_ff <= iter_ff + 8'd1;
      end
      if (cmd.esc_take) begin
         count_ff <= iter_ff + 8'd1;
      end
      if (cmd.pow_init) begin
         v_r_ff   <= red_ff;
         v_g_ff   <= green_ff;
         v_b_ff   <= blue_ff;
         pow_k_ff <= 8'd1;
      end
      if (cmd.pow_step) begin
         v_r_ff   <= div255(pr_r);
         v_g_ff   <= div255(pr_g);
         v_b_ff   <= div255(pr_b);
         pow_k_ff <= pow_k_ff + 8'd1;
      end
      if (cmd.finish) begin
         out_r_ff   <= chan_blend(mode_ff, v_r_ff, red_ff, count_ff);
         out_g_ff   <= chan_blend(mode_ff, v_g_ff, green_ff, count_ff);
         out_b_ff   <= chan_blend(mode_ff, v_b_ff, blue_ff, count_ff);
         out_cnt_ff <= count_ff;
      end
   end

   assign rsp_red_out      = out_r_ff;
   assign rsp_green_out    = out_g_ff;
   assign rsp_blue_out     = out_b_ff;
   assign rsp_escape_count = out_cnt_ff;

   `MEB_ASSERT_NXT(a_count_range, cmd.esc_take, count_ff != 8'd0 && count_ff <= max_it_ff, "count out of range")
   `MEB_ASSERT_IMP(a_pow_overlay, cmd.pow_step, mode_ff == MODE_OVERLAY, "power step outside overlay")

endmodule

`default_nettype wire

// ----- hdl/mandelbrot_escape_blend.sv -----
// ---------------------------------------------------------------------------
// Mandelbrot escape blend: top level
// Escape-time count of one pixel's point, blended into its existing color.
// ---------------------------------------------------------------------------
//
//   Channel   Ports                                   Handshake
//   -------   -------------------------------------   -------------------------
//   request   req_column/row/red_in/green_in/blue_in  start while busy is low
//   result    rsp_red/green/blue_out, escape_count    rsp_valid, one cycle
//   config    csr_index, csr_wdata                    csr_we, no wait
//
// Sequence: an accepted item runs the point setup, then the escape loop until the point
//   escapes or max_iterations is reached, then in overlay mode the power loop raising
//   each channel to the power max(count,1) (skipped in add or subtract mode), then output.
// Each escape iteration runs the registered multipliers, then the test and the
//   saturating update. Each power step multiplies by the channel and divides by 255.
// The next item is taken in the cycle in which rsp_valid is shown.
// Reset is synchronous; the receiver cannot stall, so rsp_valid is never held.
// ---------------------------------------------------------------------------
`default_nettype none

module mandelbrot_escape_blend import meb_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   // request
   input  wire logic        start,
   output logic             busy,
   input  wire logic [11:0] req_column,
   input  wire logic [11:0] req_row,
   input  wire logic [7:0]  req_red_in,
   input  wire logic [7:0]  req_green_in,
   input  wire logic [7:0]  req_blue_in,
   // result
   output logic             rsp_valid,
   output logic [7:0]       rsp_red_out,
   output logic [7:0]       rsp_green_out,
   output logic [7:0]       rsp_blue_out,
   output logic [7:0]       rsp_escape_count,
   // configuration
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   // Controller: owns the sequence and the result strobe
   meb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .sts       (sts)
   );

   // Datapath: registers, multipliers, escape update and blend
   meb_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_column       (req_column),
      .req_row          (req_row),
      .req_red_in       (req_red_in),
      .req_green_in     (req_green_in),
      .req_blue_in      (req_blue_in),
      .rsp_red_out      (rsp_red_out),
      .rsp_green_out    (rsp_green_out),
      .rsp_blue_out     (rsp_blue_out),
      .rsp_escape_count (rsp_escape_count)
   );

endmodule

`default_nettype wire
